/* sv/lpr_pkg.sv */
// Package for the IPv4 longest-prefix route table: codes, beat and entry types,
// and the prefix match function. No dependencies.
package lpr_pkg;

    localparam int LPR_TABLE_DEPTH = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVAL   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_NOROUTE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] address;
        logic [5:0]  pfx_len;
        logic [31:0] gateway;
        logic [7:0]  interface_id;
        logic [31:0] source_ip;
        logic [47:0] source_mac;
        logic        source_mac_present;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] found_network;
        logic [5:0]  found_pfx_len;
        logic [31:0] found_gateway;
        logic [7:0]  found_interface;
        logic [31:0] found_source_ip;
        logic [47:0] found_source_mac;
        logic        found_mac_valid;
    } t_rsp;

    typedef struct packed {
        logic [31:0] network;
        logic [5:0]  prefix;
        logic [31:0] gateway;
        logic [7:0]  interface_id;
        logic [31:0] source_ip;
        logic [47:0] source_mac;
        logic        mac_flag;
    } t_route;

    function automatic logic covers(logic [31:0] dst, logic [31:0] net, logic [5:0] plen);
        logic [31:0] mask;
        if (plen == 6'd0) begin
            mask = 32'h0;
        end else if (plen >= 6'd32) begin
            mask = 32'hFFFF_FFFF;
        end else begin
            mask = 32'hFFFF_FFFF << (6'd32 - plen);
        end
        return (plen <= 6'd32) && (((dst ^ net) & mask) == 32'h0);
    endfunction

endpackage

/* sv/lpr_req_if.sv */
// Request channel of the route table: valid/ready handshake and request beat.
// Depends on lpr_pkg.
interface lpr_req_if
    import lpr_pkg::*;
;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/lpr_rsp_if.sv */
// Response channel of the route table: valid/ready handshake and result beat.
// Depends on lpr_pkg.
interface lpr_rsp_if
    import lpr_pkg::*;
;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/lpr_mem.sv */
// Route entry memory: one write port, one read port with registered read data.
// Depends on lpr_pkg.
module lpr_mem
    import lpr_pkg::*;
#(
    parameter int DEPTH = LPR_TABLE_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_route        i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output t_route        o_rd_data
);

    t_route r_mem [DEPTH];
    t_route r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/lpr_ctrl.sv */
// Route table sequencer: add checks, table count, lookup scan with best-match
// tracking, and the result register. Depends on lpr_pkg, lpr_req_if, lpr_rsp_if.
module lpr_ctrl
    import lpr_pkg::*;
#(
    parameter int DEPTH = LPR_TABLE_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lpr_req_if.sink       i_req,
    lpr_rsp_if.source     o_rsp,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output t_route        o_wr_data,
    output logic [AW-1:0] o_rd_addr,
    input  t_route        i_rd_data
);

    localparam int CW = $clog2(DEPTH + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_rd_vld, n_rd_vld;
    logic          r_have, n_have;
    logic          r_lookup, n_lookup;
    logic          r_out_vld, n_out_vld;
    logic [31:0]   r_dst, n_dst;
    t_route        r_best, n_best;
    t_rsp          r_res, n_res;
    t_rsp          r_out, n_out;
    t_req          req;
    logic          accept;
    logic          bad_arg;
    logic          full;
    t_rsp          lookup_res;

    assign req     = i_req.data;
    assign accept  = i_req.valid && (r_state == ST_IDLE);
    assign bad_arg = ((req.pfx_len == 6'd0) && (req.address != 32'h0))
                     || (req.interface_id == 8'd0) || (req.pfx_len > 6'd32);
    assign full    = (r_count >= CW'(DEPTH));

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    assign o_wr_addr = r_count[AW-1:0];
    assign o_rd_addr = r_idx;
    assign o_wr_data = '{
        network:      req.address,
        prefix:       req.pfx_len,
        gateway:      req.gateway,
        interface_id: req.interface_id,
        source_ip:    req.source_ip,
        source_mac:   req.source_mac_present ? req.source_mac : 48'h0,
        mac_flag:     req.source_mac_present
    };

    always_comb begin
        lookup_res = '0;
        if (r_have) begin
            lookup_res.status           = STAT_OK;
            lookup_res.found_network    = r_best.network;
            lookup_res.found_pfx_len    = r_best.prefix;
            lookup_res.found_gateway    = r_best.gateway;
            lookup_res.found_interface  = r_best.interface_id;
            lookup_res.found_source_ip  = r_best.source_ip;
            lookup_res.found_source_mac = r_best.source_mac;
            lookup_res.found_mac_valid  = r_best.mac_flag;
        end else begin
            lookup_res.status = STAT_NOROUTE;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_rd_vld  = (r_state == ST_SCAN);
        n_have    = r_have;
        n_lookup  = r_lookup;
        n_out_vld = r_out_vld && !o_rsp.ready;
        n_dst     = r_dst;
        n_best    = r_best;
        n_res     = r_res;
        n_out     = r_out;
        o_wr_en   = 1'b0;

        if (r_rd_vld && covers(r_dst, i_rd_data.network, i_rd_data.prefix)
                && (!r_have || (i_rd_data.prefix > r_best.prefix))) begin
            n_have = 1'b1;
            n_best = i_rd_data;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res    = '0;
                    n_lookup = 1'b0;
                    n_state  = ST_RESP;
                    case (req.opcode)
                        OP_ADD: begin
                            if (bad_arg) begin
                                n_res.status = STAT_INVAL;
                            end else if (full) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                n_res.status = STAT_OK;
                                o_wr_en      = 1'b1;
                                n_count      = r_count + CW'(1);
                            end
                        end
                        OP_LOOKUP: begin
                            n_lookup = 1'b1;
                            n_have   = 1'b0;
                            n_dst    = req.address;
                            n_idx    = '0;
                            if (r_count != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_res.status = STAT_OK;
                            n_count      = '0;
                        end
                        default: begin
                            n_res.status = STAT_INVAL;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_idx = r_idx + AW'(1);
                if (r_idx == AW'(r_count - CW'(1))) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out     = r_lookup ? lookup_res : r_res;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_have    <= 1'b0;
            r_lookup  <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            r_have    <= n_have;
            r_lookup  <= n_lookup;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dst  <= n_dst;
        r_best <= n_best;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule

/* sv/ipv4_longest_prefix_route_table_top.sv */
// IPv4 longest-prefix route table. Add, clear and add checks go from idle to the response
// state; a lookup also passes the scan and drain states (both skipped on an empty table),
// walking route_count entries (up to TABLE_DEPTH) on the route memory's single read port
// one entry per cycle while the longest match (earliest on a tie) is kept in a register.
// Each result sits in an output register, so the next request beat is taken while a
// result waits. Depends on lpr_pkg, lpr_req_if, lpr_rsp_if, lpr_mem and lpr_ctrl.
module ipv4_longest_prefix_route_table_top
    import lpr_pkg::*;
#(
    parameter int TABLE_DEPTH = LPR_TABLE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpr_req_if.sink   i_req,
    lpr_rsp_if.source o_rsp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_route        wr_data;
    logic [AW-1:0] rd_addr;
    t_route        rd_data;

    lpr_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    lpr_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
